/* design/qplr_pkg.sv */
package qplr_pkg;

    localparam int PITCH_W     = 13;
    localparam int COLOR_W     = 8;
    localparam int STEP_PIXELS = 4;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int CREDIT_W    = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_START    = 1'b0;
    localparam logic CMD_CONTINUE = 1'b1;

    localparam logic [PITCH_W-1:0] PITCH_RESET = 13'd640;

    typedef enum logic [3:0] {
        KIND_IDLE  = 4'b0001,
        KIND_VERT  = 4'b0010,
        KIND_HORIZ = 4'b0100,
        KIND_WALK  = 4'b1000
    } line_kind_t;

endpackage

/* design/quad_point_line_rasterizer.sv */
// Channel   Handshake              Payload
// input     push / full            command, x_start, y_start, x_end, y_end, pen_color
// result    empty / pop            addr_a..addr_d, write_a..write_d, pixel_color, line_done
// config    cfg_valid / cfg_ready  cfg_data (row_pitch)
//
// One item per cycle sustained while each result is popped; each item yields one result.
// The rate is set by the step unit, which updates the walk pointers and error once per item it takes.
// Reset: row_pitch is 640, no line is active and the line color is zero.
// full rises while four items sit between the input register and the step unit.
// A stalled pop holds the result register; the queue then fills and full follows.
module quad_point_line_rasterizer #(
    parameter int COORD_BITS = 12,
    parameter int ADDR_BITS  = 24
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         command,
    input  logic [COORD_BITS-1:0]        x_start,
    input  logic [COORD_BITS-1:0]        y_start,
    input  logic [COORD_BITS-1:0]        x_end,
    input  logic [COORD_BITS-1:0]        y_end,
    input  logic [qplr_pkg::COLOR_W-1:0] pen_color,
    output logic                         empty,
    input  logic                         pop,
    output logic [ADDR_BITS-1:0]         addr_a,
    output logic [ADDR_BITS-1:0]         addr_b,
    output logic [ADDR_BITS-1:0]         addr_c,
    output logic [ADDR_BITS-1:0]         addr_d,
    output logic                         write_a,
    output logic                         write_b,
    output logic                         write_c,
    output logic                         write_d,
    output logic [qplr_pkg::COLOR_W-1:0] pixel_color,
    output logic                         line_done,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [qplr_pkg::PITCH_W-1:0] cfg_data
);
    import qplr_pkg::*;

    localparam int ENTRY_W = 3 * ADDR_BITS + 4 * COORD_BITS + 17;

    logic [PITCH_W-1:0] row_pitch_reg;
    logic               fe_valid;
    logic [ENTRY_W-1:0] fe_data;
    logic               q_valid;
    logic [ENTRY_W-1:0] q_data;
    logic               q_take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pitch_reg <= PITCH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            row_pitch_reg <= cfg_data;
        end
    end

    qplr_front #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .command     (command),
        .x_start     (x_start),
        .y_start     (y_start),
        .x_end       (x_end),
        .y_end       (y_end),
        .pen_color   (pen_color),
        .row_pitch   (row_pitch_reg),
        .entry_valid (fe_valid),
        .entry_data  (fe_data),
        .entry_taken (q_take)
    );

    qplr_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fe_valid),
        .wr_data  (fe_data),
        .rd_en    (q_take),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    qplr_back #(
        .COORD_BITS (COORD_BITS),
        .ADDR_BITS  (ADDR_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .row_pitch   (row_pitch_reg),
        .entry_valid (q_valid),
        .entry_data  (q_data),
        .entry_take  (q_take),
        .empty       (empty),
        .pop         (pop),
        .addr_a      (addr_a),
        .addr_b      (addr_b),
        .addr_c      (addr_c),
        .addr_d      (addr_d),
        .write_a     (write_a),
        .write_b     (write_b),
        .write_c     (write_c),
        .write_d     (write_d),
        .pixel_color (pixel_color),
        .line_done   (line_done)
    );

endmodule

/* design/qplr_front.sv */
module qplr_front #(
    parameter int COORD_BITS = 12,
    parameter int ADDR_BITS  = 24,
    localparam int ENTRY_W   = 3 * ADDR_BITS + 4 * COORD_BITS + 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        command,
    input  logic [COORD_BITS-1:0]       x_start,
    input  logic [COORD_BITS-1:0]       y_start,
    input  logic [COORD_BITS-1:0]       x_end,
    input  logic [COORD_BITS-1:0]       y_end,
    input  logic [qplr_pkg::COLOR_W-1:0] pen_color,
    input  logic [qplr_pkg::PITCH_W-1:0] row_pitch,
    output logic                        entry_valid,
    output logic [ENTRY_W-1:0]          entry_data,
    input  logic                        entry_taken
);
    import qplr_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int AW = ADDR_BITS;
    localparam int EW = COORD_BITS + 2;
    localparam int PW = PITCH_W + COORD_BITS;
    localparam int OW = (AW > PW + 1) ? AW : PW + 1;

    typedef struct packed {
        logic                 cmd;
        line_kind_t           kind;
        logic [AW-1:0]        ptr0;
        logic [AW-1:0]        ptr1;
        logic [AW-1:0]        ptrm;
        logic [CW-1:0]        steps;
        logic [CW-1:0]        major;
        logic [CW-1:0]        minor;
        logic signed [EW-1:0] err;
        logic                 down;
        logic                 xmaj;
        logic [COLOR_W-1:0]   color;
    } entry_t;

    function automatic logic [AW-1:0] offset_of(input logic [PITCH_W-1:0] pitch,
                                                input logic [CW-1:0] x,
                                                input logic [CW-1:0] y);
        logic [OW-1:0] sum;
        sum = OW'(pitch) * OW'(y) + OW'(x);
        return sum[AW-1:0];
    endfunction

    logic                  accept;
    logic [CREDIT_W-1:0]   credit_reg;
    logic [CREDIT_W-1:0]   credit_next;

    logic                  s1_valid_reg;
    logic                  s1_cmd_reg;
    logic [CW-1:0]         s1_xs_reg;
    logic [CW-1:0]         s1_ys_reg;
    logic [CW-1:0]         s1_xe_reg;
    logic [CW-1:0]         s1_ye_reg;
    logic [COLOR_W-1:0]    s1_color_reg;

    logic                  vert;
    logic                  swap;
    logic                  horiz;
    logic                  down;
    logic                  xmaj;
    logic [CW-1:0]         ylo;
    logic [CW-1:0]         yhi;
    logic [CW-1:0]         x1;
    logic [CW-1:0]         y1;
    logic [CW-1:0]         x2;
    logic [CW-1:0]         y2;
    logic [CW-1:0]         dx;
    logic [CW-1:0]         dy;
    logic [CW-1:0]         midx;
    logic [CW-1:0]         midy;
    logic [CW-1:0]         major;
    logic [CW-1:0]         minor;
    logic [CW-1:0]         steps;
    logic [CW:0]           vspan;
    logic signed [EW-1:0]  err;
    line_kind_t            kind;
    logic [CW-1:0]         p0x;
    logic [CW-1:0]         p0y;
    logic [CW-1:0]         p1x;
    logic [CW-1:0]         p1y;

    logic                  s2_valid_reg;
    logic                  s2_cmd_reg;
    line_kind_t            s2_kind_reg;
    logic [CW-1:0]         s2_p0x_reg;
    logic [CW-1:0]         s2_p0y_reg;
    logic [CW-1:0]         s2_p1x_reg;
    logic [CW-1:0]         s2_p1y_reg;
    logic [CW-1:0]         s2_midx_reg;
    logic [CW-1:0]         s2_midy_reg;
    logic [CW-1:0]         s2_steps_reg;
    logic [CW-1:0]         s2_major_reg;
    logic [CW-1:0]         s2_minor_reg;
    logic signed [EW-1:0]  s2_err_reg;
    logic                  s2_down_reg;
    logic                  s2_xmaj_reg;
    logic [COLOR_W-1:0]    s2_color_reg;

    entry_t                entry;

    assign full   = (credit_reg == CREDIT_W'(QUEUE_DEPTH));
    assign accept = push && !full;

    always_comb
    begin
        credit_next = credit_reg;
        if (accept && !entry_taken)
        begin
            credit_next = credit_reg + CREDIT_W'(1);
        end
        else if (!accept && entry_taken)
        begin
            credit_next = credit_reg - CREDIT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg   <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            credit_reg   <= credit_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg   <= command;
            s1_xs_reg    <= x_start;
            s1_ys_reg    <= y_start;
            s1_xe_reg    <= x_end;
            s1_ye_reg    <= y_end;
            s1_color_reg <= pen_color;
        end
    end

    // classify the line and order its endpoints
    always_comb
    begin
        vert  = (s1_xs_reg == s1_xe_reg);
        ylo   = (s1_ys_reg < s1_ye_reg) ? s1_ys_reg : s1_ye_reg;
        yhi   = (s1_ys_reg < s1_ye_reg) ? s1_ye_reg : s1_ys_reg;
        swap  = (s1_xs_reg > s1_xe_reg);
        x1    = swap ? s1_xe_reg : s1_xs_reg;
        y1    = swap ? s1_ye_reg : s1_ys_reg;
        x2    = swap ? s1_xs_reg : s1_xe_reg;
        y2    = swap ? s1_ys_reg : s1_ye_reg;
        horiz = (y1 == y2);
        dx    = x2 - x1;
        down  = (y1 < y2);
        dy    = down ? (y2 - y1) : (y1 - y2);
        midx  = x1 + (dx >> 1);
        midy  = down ? (y1 + (dy >> 1)) : (y1 - (dy >> 1));
        xmaj  = (dx > dy);
        major = xmaj ? dx : dy;
        minor = xmaj ? dy : dx;
        err   = $signed({2'b00, minor}) - $signed({3'b000, major[CW-1:1]});
        vspan = {1'b0, yhi} - {1'b0, ylo} + (CW + 1)'(1);
        p0x   = x1;
        p0y   = y1;
        p1x   = x2;
        p1y   = y2;
        if (vert)
        begin
            kind  = KIND_VERT;
            p0x   = s1_xs_reg;
            p0y   = ylo;
            p1x   = s1_xs_reg;
            p1y   = yhi;
            steps = (row_pitch != '0) ? vspan[CW:1] : '0;
        end
        else if (horiz)
        begin
            kind  = KIND_HORIZ;
            steps = dx;
        end
        else
        begin
            kind  = KIND_WALK;
            steps = {2'b00, major[CW-1:2]};
        end
    end

    always_ff @(posedge clk)
    begin
        s2_cmd_reg   <= s1_cmd_reg;
        s2_kind_reg  <= kind;
        s2_p0x_reg   <= p0x;
        s2_p0y_reg   <= p0y;
        s2_p1x_reg   <= p1x;
        s2_p1y_reg   <= p1y;
        s2_midx_reg  <= midx;
        s2_midy_reg  <= midy;
        s2_steps_reg <= steps;
        s2_major_reg <= major;
        s2_minor_reg <= minor;
        s2_err_reg   <= err;
        s2_down_reg  <= down;
        s2_xmaj_reg  <= xmaj;
        s2_color_reg <= s1_color_reg;
    end

    // turn coordinates into byte offsets
    always_comb
    begin
        entry.cmd   = s2_cmd_reg;
        entry.kind  = s2_kind_reg;
        entry.ptr0  = offset_of(row_pitch, s2_p0x_reg, s2_p0y_reg);
        entry.ptr1  = offset_of(row_pitch, s2_p1x_reg, s2_p1y_reg);
        entry.ptrm  = offset_of(row_pitch, s2_midx_reg, s2_midy_reg);
        entry.steps = s2_steps_reg;
        entry.major = s2_major_reg;
        entry.minor = s2_minor_reg;
        entry.err   = s2_err_reg;
        entry.down  = s2_down_reg;
        entry.xmaj  = s2_xmaj_reg;
        entry.color = s2_color_reg;
    end

    assign entry_valid = s2_valid_reg;
    assign entry_data  = entry;

`ifndef SYNTHESIS
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CREDIT_W'(QUEUE_DEPTH))
        else $error("front credit count above queue depth");
    a_taken_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (entry_taken || s2_valid_reg) |-> (credit_reg != '0))
        else $error("item in flight with no credit held");
`endif

endmodule

/* design/qplr_queue.sv */
module qplr_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic             rd_valid,
    output logic [WIDTH-1:0] rd_data
);
    import qplr_pkg::*;

    logic [WIDTH-1:0]    mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [CREDIT_W-1:0] count_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [CREDIT_W-1:0] count_next;
    logic                do_rd;

    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem[rd_ptr_reg];
    assign do_rd    = rd_en && rd_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (wr_en && !do_rd)
        begin
            count_next = count_reg + CREDIT_W'(1);
        end
        else if (!wr_en && do_rd)
        begin
            count_next = count_reg - CREDIT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg != CREDIT_W'(QUEUE_DEPTH)))
        else $error("write into a full queue");
`endif

endmodule

/* design/qplr_back.sv */
module qplr_back #(
    parameter int COORD_BITS = 12,
    parameter int ADDR_BITS  = 24,
    localparam int ENTRY_W   = 3 * ADDR_BITS + 4 * COORD_BITS + 17
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [qplr_pkg::PITCH_W-1:0] row_pitch,
    input  logic                         entry_valid,
    input  logic [ENTRY_W-1:0]           entry_data,
    output logic                         entry_take,
    output logic                         empty,
    input  logic                         pop,
    output logic [ADDR_BITS-1:0]         addr_a,
    output logic [ADDR_BITS-1:0]         addr_b,
    output logic [ADDR_BITS-1:0]         addr_c,
    output logic [ADDR_BITS-1:0]         addr_d,
    output logic                         write_a,
    output logic                         write_b,
    output logic                         write_c,
    output logic                         write_d,
    output logic [qplr_pkg::COLOR_W-1:0] pixel_color,
    output logic                         line_done
);
    import qplr_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int AW = ADDR_BITS;
    localparam int EW = COORD_BITS + 2;

    typedef struct packed {
        logic                 cmd;
        line_kind_t           kind;
        logic [AW-1:0]        ptr0;
        logic [AW-1:0]        ptr1;
        logic [AW-1:0]        ptrm;
        logic [CW-1:0]        steps;
        logic [CW-1:0]        major;
        logic [CW-1:0]        minor;
        logic signed [EW-1:0] err;
        logic                 down;
        logic                 xmaj;
        logic [COLOR_W-1:0]   color;
    } entry_t;

    entry_t                e;
    logic                  take;
    logic                  start;

    line_kind_t            kind_reg;
    logic [AW-1:0]         p0_reg;
    logic [AW-1:0]         p1_reg;
    logic [AW-1:0]         pmf_reg;
    logic [AW-1:0]         pmb_reg;
    logic [CW-1:0]         steps_reg;
    logic [CW-1:0]         major_reg;
    logic [CW-1:0]         minor_reg;
    logic signed [EW-1:0]  err_reg;
    logic                  down_reg;
    logic                  xmaj_reg;
    logic [COLOR_W-1:0]    color_reg;

    line_kind_t            s_kind;
    logic [AW-1:0]         s_p0;
    logic [AW-1:0]         s_p1;
    logic [AW-1:0]         s_pmf;
    logic [AW-1:0]         s_pmb;
    logic [CW-1:0]         s_steps;
    logic [CW-1:0]         s_major;
    logic [CW-1:0]         s_minor;
    logic signed [EW-1:0]  s_err;
    logic                  s_down;
    logic                  s_xmaj;
    logic [COLOR_W-1:0]    s_color;

    logic [AW-1:0]         pitch_a;
    logic [AW-1:0]         dy_ptr;
    logic [AW-1:0]         d_major;
    logic [AW-1:0]         d_both;

    line_kind_t            kind_next;
    logic [AW-1:0]         p0_next;
    logic [AW-1:0]         p1_next;
    logic [AW-1:0]         pmf_next;
    logic [AW-1:0]         pmb_next;
    logic [CW-1:0]         steps_next;
    logic signed [EW-1:0]  err_next;
    logic [AW-1:0]         adv;
    logic [AW-1:0]         a0;
    logic [AW-1:0]         a1;
    logic [AW-1:0]         a2;
    logic [AW-1:0]         a3;
    logic [3:0]            w;
    logic                  done;

    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic [AW-1:0]         addr_a_reg;
    logic [AW-1:0]         addr_b_reg;
    logic [AW-1:0]         addr_c_reg;
    logic [AW-1:0]         addr_d_reg;
    logic [3:0]            write_reg;
    logic [COLOR_W-1:0]    color_out_reg;
    logic                  done_reg;

    assign e          = entry_data;
    assign take       = entry_valid && (!out_valid_reg || pop);
    assign entry_take = take;
    assign start      = (e.cmd == CMD_START);

    always_comb
    begin
        s_kind  = start ? e.kind  : kind_reg;
        s_p0    = start ? e.ptr0  : p0_reg;
        s_p1    = start ? e.ptr1  : p1_reg;
        s_pmf   = start ? e.ptrm  : pmf_reg;
        s_pmb   = start ? e.ptrm  : pmb_reg;
        s_steps = start ? e.steps : steps_reg;
        s_major = start ? e.major : major_reg;
        s_minor = start ? e.minor : minor_reg;
        s_err   = start ? e.err   : err_reg;
        s_down  = start ? e.down  : down_reg;
        s_xmaj  = start ? e.xmaj  : xmaj_reg;
        s_color = start ? e.color : color_reg;
    end

    // walk deltas follow the current row pitch
    always_comb
    begin
        pitch_a = AW'(row_pitch);
        dy_ptr  = s_down ? pitch_a : (AW'(0) - pitch_a);
        if (s_kind == KIND_VERT)
        begin
            d_major = pitch_a;
        end
        else
        begin
            d_major = s_xmaj ? AW'(1) : dy_ptr;
        end
        d_both = dy_ptr + AW'(1);
    end

    always_comb
    begin
        p0_next    = s_p0;
        p1_next    = s_p1;
        pmf_next   = s_pmf;
        pmb_next   = s_pmb;
        steps_next = s_steps;
        err_next   = s_err;
        adv        = d_major;
        a0         = '0;
        a1         = '0;
        a2         = '0;
        a3         = '0;
        w          = 4'b0000;
        done       = 1'b1;
        case (s_kind)
            KIND_VERT:
            begin
                if (s_steps != '0)
                begin
                    a0         = s_p0;
                    a1         = s_p1;
                    w          = 4'b0011;
                    p0_next    = s_p0 + d_major;
                    p1_next    = s_p1 - d_major;
                    steps_next = s_steps - CW'(1);
                end
                done = (steps_next == '0);
            end
            KIND_HORIZ:
            begin
                w[0] = (s_steps != '0);
                w[1] = (s_steps > CW'(1));
                w[2] = (s_steps > CW'(2));
                w[3] = (s_steps > CW'(3));
                a0   = w[0] ? s_p0 : '0;
                a1   = w[1] ? s_p0 + AW'(1) : '0;
                a2   = w[2] ? s_p0 + AW'(2) : '0;
                a3   = w[3] ? s_p0 + AW'(3) : '0;
                p0_next    = s_p0 + AW'(STEP_PIXELS);
                steps_next = w[3] ? s_steps - CW'(STEP_PIXELS) : '0;
                done       = !(s_steps > CW'(STEP_PIXELS));
            end
            KIND_WALK:
            begin
                a0 = s_p0;
                a1 = s_p1;
                a2 = s_pmf;
                a3 = s_pmb;
                w  = 4'b1111;
                if (s_steps != '0)
                begin
                    // a non-negative error also takes a minor-axis step
                    if (!s_err[EW-1])
                    begin
                        adv      = d_both;
                        err_next = s_err + $signed({2'b00, s_minor})
                                         - $signed({2'b00, s_major});
                    end
                    else
                    begin
                        err_next = s_err + $signed({2'b00, s_minor});
                    end
                    p0_next    = s_p0 + adv;
                    pmf_next   = s_pmf + adv;
                    p1_next    = s_p1 - adv;
                    pmb_next   = s_pmb - adv;
                    steps_next = s_steps - CW'(1);
                    done       = 1'b0;
                end
            end
            default:
            begin
                done = 1'b1;
            end
        endcase
        kind_next = done ? KIND_IDLE : s_kind;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg      <= KIND_IDLE;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                kind_reg  <= kind_next;
                color_reg <= s_color;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            p0_reg        <= p0_next;
            p1_reg        <= p1_next;
            pmf_reg       <= pmf_next;
            pmb_reg       <= pmb_next;
            steps_reg     <= steps_next;
            major_reg     <= s_major;
            minor_reg     <= s_minor;
            err_reg       <= err_next;
            down_reg      <= s_down;
            xmaj_reg      <= s_xmaj;
            addr_a_reg    <= a0;
            addr_b_reg    <= a1;
            addr_c_reg    <= a2;
            addr_d_reg    <= a3;
            write_reg     <= w;
            color_out_reg <= s_color;
            done_reg      <= done;
        end
    end

    assign empty       = !out_valid_reg;
    assign addr_a      = addr_a_reg;
    assign addr_b      = addr_b_reg;
    assign addr_c      = addr_c_reg;
    assign addr_d      = addr_d_reg;
    assign write_a     = write_reg[0];
    assign write_b     = write_reg[1];
    assign write_c     = write_reg[2];
    assign write_d     = write_reg[3];
    assign pixel_color = color_out_reg;
    assign line_done   = done_reg;

`ifndef SYNTHESIS
    a_writes_packed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((!write_reg[3] || write_reg[2]) && (!write_reg[2] || write_reg[1])
                           && (!write_reg[1] || write_reg[0])))
        else $error("pixel write enables not filled from the first lane");
    a_open_step_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !done_reg) |-> write_reg[0])
        else $error("step of an open line carries no pixel write");
`endif

endmodule
